// ===== hw/rtl/erm_pkg.sv =====
package erm_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_CHECK = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// access size codes; codes above SIZE_128 also mean 128 bits
	localparam logic [2:0] SIZE_8   = 3'd0;
	localparam logic [2:0] SIZE_16  = 3'd1;
	localparam logic [2:0] SIZE_32  = 3'd2;
	localparam logic [2:0] SIZE_128 = 3'd4;

	// one accepted item as held in the input register
	typedef struct packed {
		logic        valid;
		opcode_t     opcode;
		logic [1:0]  core_id;
		logic [63:0] address;
		logic [2:0]  size_code;
		logic [63:0] load_low;
		logic [63:0] load_high;
	} req_t;

	// outcome of one item
	typedef struct packed {
		logic        pass;
		logic [63:0] expected_low;
		logic [63:0] expected_high;
	} rsp_t;

	function automatic logic [63:0] low_mask(input logic [2:0] size_code);
		logic [63:0] m;
		begin
			unique case (size_code)
				SIZE_8:  m = 64'h0000_0000_0000_00FF;
				SIZE_16: m = 64'h0000_0000_0000_FFFF;
				SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
				default: m = '1;
			endcase
			return m;
		end
	endfunction

	function automatic logic [63:0] high_mask(input logic [2:0] size_code);
		return (size_code >= SIZE_128) ? '1 : '0;
	endfunction

endpackage

// ===== hw/rtl/erm_resv_table.sv =====
module erm_resv_table #(
	parameter int CORE_COUNT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  erm_pkg::req_t req,
	output erm_pkg::rsp_t rsp
);

	logic [CORE_COUNT-1:0] valid_q;
	logic [63:0]           addr_q [CORE_COUNT];
	logic [63:0]           low_q  [CORE_COUNT];
	logic [63:0]           high_q [CORE_COUNT];

	logic [CORE_COUNT-1:0] own;
	logic [CORE_COUNT-1:0] addr_hit;
	logic                  check_pass;
	logic [63:0]           own_low;
	logic [63:0]           own_high;
	logic [63:0]           lmask;
	logic [63:0]           hmask;
	logic                  do_mark;
	logic                  do_clear;
	logic                  do_drop;

	assign lmask = erm_pkg::low_mask(req.size_code);
	assign hmask = erm_pkg::high_mask(req.size_code);

	// per-entry decode and address compare
	always_comb begin
		own_low  = '0;
		own_high = '0;
		for (int k = 0; k < CORE_COUNT; k++) begin
			own[k]      = (int'(req.core_id) == k);
			addr_hit[k] = valid_q[k] && (addr_q[k] == req.address);
			if (own[k]) begin
				own_low  = own_low | low_q[k];
				own_high = own_high | high_q[k];
			end
		end
	end

	assign check_pass = |(own & addr_hit);

	assign do_mark  = req.valid && (req.opcode == erm_pkg::OP_MARK);
	assign do_clear = req.valid && (req.opcode == erm_pkg::OP_CLEAR);
	assign do_drop  = req.valid && (req.opcode == erm_pkg::OP_CHECK) && check_pass;

	always_comb begin
		rsp = '0;
		unique case (req.opcode)
			erm_pkg::OP_MARK:  rsp.pass = 1'b1;
			erm_pkg::OP_CLEAR: rsp.pass = 1'b1;
			erm_pkg::OP_CHECK: begin
				if (check_pass) begin
					rsp.pass          = 1'b1;
					rsp.expected_low  = own_low & lmask;
					rsp.expected_high = own_high & hmask;
				end
			end
			erm_pkg::OP_NOP:   rsp.pass = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < CORE_COUNT; k++) begin
				if (do_mark && own[k]) begin
					valid_q[k] <= 1'b1;
				end else if (do_clear && own[k]) begin
					valid_q[k] <= 1'b0;
				end else if (do_drop && addr_hit[k]) begin
					valid_q[k] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CORE_COUNT; k++) begin
			if (do_mark && own[k]) begin
				addr_q[k] <= req.address;
				low_q[k]  <= req.load_low & lmask;
				high_q[k] <= req.load_high & hmask;
			end
		end
	end

endmodule

// ===== hw/rtl/exclusive_reservation_monitor.sv =====
// exclusive reservation monitor: one reservation per core (valid mark, address,
// up to 128 bits of saved load data). an item is taken on any edge with start
// high; busy never rises, so one item can enter every cycle. each item gives
// exactly one result, shown on pass/expected_low/expected_high for one cycle
// with done high. done rises at the edge after the accepting edge: the
// input register feeds the reservation table's compare, and the next edge
// loads the result register and updates the table together. the receiver
// cannot stall, and none is needed since every item leaves on a fixed schedule.
// mark stores address and data masked to the access size; clear drops the
// core's reservation; a store check passes when the core holds a reservation
// on exactly that address, then drops every reservation on that address and
// returns the saved value masked to size
module exclusive_reservation_monitor #(
	parameter int CORE_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  core_id,
	input  logic [63:0] address,
	input  logic [2:0]  size_code,
	input  logic [63:0] load_low,
	input  logic [63:0] load_high,
	output logic        done,
	output logic        pass,
	output logic [63:0] expected_low,
	output logic [63:0] expected_high
);

	erm_pkg::req_t req_s1;
	erm_pkg::rsp_t rsp;
	erm_pkg::rsp_t rsp_q;
	logic          done_q;

	// table works in a single pass, so the block is always ready
	assign busy = 1'b0;

	// input register: cleared under reset, loaded every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1.valid     <= start;
			req_s1.opcode    <= erm_pkg::opcode_t'(opcode);
			req_s1.core_id   <= core_id;
			req_s1.address   <= address;
			req_s1.size_code <= size_code;
			req_s1.load_low  <= load_low;
			req_s1.load_high <= load_high;
		end
	end

	// reservation entries, compare and update
	erm_resv_table #(
		.CORE_COUNT(CORE_COUNT)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_s1),
		.rsp   (rsp)
	);

	// result register: strobe for one cycle per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp;
	end

	assign done          = done_q;
	assign pass          = rsp_q.pass;
	assign expected_low  = rsp_q.expected_low;
	assign expected_high = rsp_q.expected_high;

endmodule

// ===== tb/exclusive_reservation_checker.sv =====
`timescale 1ns / 1ps

module exclusive_reservation_checker
	import erm_pkg::*;
#(
	parameter int CORE_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  core_id,
	input  logic [63:0] address,
	input  logic [2:0]  size_code,
	input  logic [63:0] load_low,
	input  logic [63:0] load_high,
	input  logic        done,
	input  logic        pass,
	input  logic [63:0] expected_low,
	input  logic [63:0] expected_high,
	output int          failures,
	output int          pending
);

	// per-core reservation table as the monitor should hold it
	logic        held      [CORE_COUNT];
	logic [63:0] held_addr [CORE_COUNT];
	logic [63:0] held_low  [CORE_COUNT];
	logic [63:0] held_high [CORE_COUNT];

	rsp_t expected_rsps [$];

	// low word mask: 8, 16, 32 bits, anything else is a full word
	function automatic logic [63:0] low_word_mask(input logic [2:0] sz);
		return (sz < 3'd3) ? ((64'd1 << (8 << sz)) - 64'd1) : '1;
	endfunction

	// apply one item to the table and return the result it must produce
	function automatic rsp_t resolve_access(input opcode_t op, input logic [1:0] core,
			input logic [63:0] addr, input logic [2:0] sz,
			input logic [63:0] lo, input logic [63:0] hi);
		rsp_t r;
		int k;
		r = '0;
		case (op)
			OP_MARK: begin
				if (core < CORE_COUNT) begin
					held[core]      = 1'b1;
					held_addr[core] = addr;
					held_low[core]  = lo & low_word_mask(sz);
					held_high[core] = hi & {64{sz >= SIZE_128}};
				end
				r.pass = 1'b1;
			end
			OP_CHECK: begin
				if (core < CORE_COUNT && held[core] && held_addr[core] == addr) begin
					r.pass          = 1'b1;
					r.expected_low  = held_low[core] & low_word_mask(sz);
					r.expected_high = held_high[core] & {64{sz >= SIZE_128}};
					for (k = 0; k < CORE_COUNT; k++)
						if (held[k] && held_addr[k] == addr)
							held[k] = 1'b0;
				end
			end
			OP_CLEAR: begin
				if (core < CORE_COUNT)
					held[core] = 1'b0;
				r.pass = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		int errs;
		if (!arst_n) begin
			foreach (held[k])
				held[k] = 1'b0;
			expected_rsps.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			errs = 0;
			if (start && !busy)
				expected_rsps.push_back(resolve_access(opcode_t'(opcode), core_id, address,
					size_code, load_low, load_high));
			if (done) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no item waiting: pass %0h low %0h high %0h",
						pass, expected_low, expected_high);
					errs++;
				end else begin
					want = expected_rsps.pop_front();
					if (pass !== want.pass) begin
						$error("pass: expected %0h, got %0h", want.pass, pass);
						errs++;
					end
					if (expected_low !== want.expected_low) begin
						$error("expected_low: expected %0h, got %0h",
							want.expected_low, expected_low);
						errs++;
					end
					if (expected_high !== want.expected_high) begin
						$error("expected_high: expected %0h, got %0h",
							want.expected_high, expected_high);
						errs++;
					end
				end
			end
			failures <= failures + errs;
			pending  <= expected_rsps.size();
		end
	end

endmodule

// ===== tb/exclusive_reservation_monitor_test.sv =====
`timescale 1ns / 1ps

module exclusive_reservation_monitor_test;
	import erm_pkg::*;

	localparam int CORES        = 4;
	localparam int RANDOM_ITEMS = 1500;
	// last stretch of the random part runs back to back
	localparam int CALM_TAIL    = 200;
	localparam int CYCLE_LIMIT  = 200000;

	// size codes the package leaves unnamed
	localparam logic [2:0] SIZE_64      = 3'd3;
	localparam logic [2:0] SIZE_ODD_MIN = 3'd5;
	localparam logic [2:0] SIZE_ODD_MAX = 3'd7;

	localparam logic [63:0] ADDR_A = 64'h0000_1000_0000_0040;
	localparam logic [63:0] ADDR_B = 64'h8000_0000_0000_0000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [1:0]  core_id;
	logic [63:0] address;
	logic [2:0]  size_code;
	logic [63:0] load_low;
	logic [63:0] load_high;
	logic        done;
	logic        pass;
	logic [63:0] expected_low;
	logic [63:0] expected_high;

	int failures;
	int pending;
	int cycle_count;

	// last address each core marked, so checks can aim at live reservations
	logic [63:0] last_mark [CORES];

	// random stimulus scratch
	int          i;
	int          pick;
	int          idle_odds;
	opcode_t     op;
	logic [1:0]  core;
	logic [63:0] addr;

	exclusive_reservation_monitor #(
		.CORE_COUNT(CORES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.core_id      (core_id),
		.address      (address),
		.size_code    (size_code),
		.load_low     (load_low),
		.load_high    (load_high),
		.done         (done),
		.pass         (pass),
		.expected_low (expected_low),
		.expected_high(expected_high)
	);

	// predicts every result and compares it as it leaves the block
	exclusive_reservation_checker #(
		.CORE_COUNT(CORES)
	) reservation_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.core_id      (core_id),
		.address      (address),
		.size_code    (size_code),
		.load_low     (load_low),
		.load_high    (load_high),
		.done         (done),
		.pass         (pass),
		.expected_low (expected_low),
		.expected_high(expected_high),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop if the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL exclusive_reservation_monitor");
		$finish;
	end

	// present one item and hold it until the block takes it
	task automatic issue_access(input opcode_t o, input logic [1:0] c, input logic [63:0] a,
			input logic [2:0] sz, input logic [63:0] lo, input logic [63:0] hi);
		opcode    <= o;
		core_id   <= c;
		address   <= a;
		size_code <= sz;
		load_low  <= lo;
		load_high <= hi;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		if (o == OP_MARK)
			last_mark[c] = a;
	endtask

	// sender gap
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every predicted result has come out
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly a few shared hot addresses so cores collide, sometimes anything
	function automatic logic [63:0] pick_address();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return ADDR_A;
			3: return ADDR_B;
			4: return 64'h0000_7fff_ffff_fff8;
			5: return 64'h1234_5678_9abc_def0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		foreach (last_mark[k])
			last_mark[k] = '0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		opcode    <= OP_NOP;
		core_id   <= '0;
		address   <= '0;
		size_code <= '0;
		load_low  <= '0;
		load_high <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every core gets a reservation first, so no unwritten entry is ever read
		issue_access(OP_MARK, 2'd0, '0, SIZE_128, '1, '1);
		issue_access(OP_MARK, 2'd1, '1, SIZE_8, '1, '1);
		issue_access(OP_MARK, 2'd2, ADDR_A, SIZE_ODD_MAX,
			64'hdead_beef_0123_4567, 64'h89ab_cdef_fedc_ba98);
		issue_access(OP_MARK, 2'd3, ADDR_A, SIZE_16, 64'h5555_5555_5555_5555, '1);
		// full 128-bit pass, then the same check again must fail
		issue_access(OP_CHECK, 2'd0, '0, SIZE_128, '0, '0);
		issue_access(OP_CHECK, 2'd0, '0, SIZE_128, '0, '0);
		// check narrower than the mark, and it knocks out core 3 on the same address
		issue_access(OP_CHECK, 2'd2, ADDR_A, SIZE_32, '0, '0);
		issue_access(OP_CHECK, 2'd3, ADDR_A, SIZE_16, '0, '0);
		// byte mark read back as a 64-bit check: upper bits stored as zero
		issue_access(OP_CHECK, 2'd1, '1, SIZE_64, '0, '0);
		// wrong address fails and keeps the reservation, clear then drops it
		issue_access(OP_MARK, 2'd1, ADDR_B, SIZE_ODD_MIN,
			64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		issue_access(OP_CHECK, 2'd1, ADDR_B ^ 64'd1, SIZE_128, '0, '0);
		issue_access(OP_CLEAR, 2'd1, ADDR_B, SIZE_8, '0, '0);
		issue_access(OP_CHECK, 2'd1, ADDR_B, SIZE_128, '0, '0);
		// no-op code with every field at its top
		issue_access(OP_NOP, 2'd3, '1, SIZE_ODD_MAX, '1, '1);
		// odd size codes act as 128 bits on both mark and check
		issue_access(OP_MARK, 2'd2, ADDR_B, 3'd6, '1, '1);
		issue_access(OP_CHECK, 2'd2, ADDR_B, 3'd6, '0, '0);
		// 32-bit mark checked as a byte
		issue_access(OP_MARK, 2'd0, 64'd7, SIZE_32, '1, '1);
		issue_access(OP_CHECK, 2'd0, 64'd7, SIZE_8, '0, '0);
		// clear of a core with nothing reserved
		issue_access(OP_CLEAR, 2'd3, '1, SIZE_ODD_MAX, '1, '1);
		drain_results();

		// random part: mark/check pairs dominate so checks often pass
		idle_odds = 0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// each block of items draws its own gap density, zero means none
			if (i % 100 == 0)
				idle_odds = $urandom_range(0, 3);
			if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3)
				drain_results();
			pick = $urandom_range(0, 99);
			core = 2'($urandom_range(0, CORES - 1));
			if (pick < 35)
				op = OP_MARK;
			else if (pick < 80)
				op = OP_CHECK;
			else if (pick < 93)
				op = OP_CLEAR;
			else
				op = OP_NOP;
			if (op == OP_CHECK && $urandom_range(0, 9) < 6)
				addr = last_mark[core];
			else
				addr = pick_address();
			issue_access(op, core, addr, 3'($urandom_range(0, 7)),
				{$urandom, $urandom}, {$urandom, $urandom});
			if (i < RANDOM_ITEMS - CALM_TAIL && idle_odds != 0
					&& $urandom_range(0, 9) < idle_odds)
				hold_off($urandom_range(1, 7));
		end

		// let the pipeline empty, then a few more cycles for stray results
		drain_results();
		repeat (4) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS exclusive_reservation_monitor");
		else
			$display("FAIL exclusive_reservation_monitor");
		$finish;
	end

endmodule
